// ----- sv/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character constants and helpers for the escaper blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  // Character codes used by the escaper.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_U         = 8'h75;

  // Control bytes with a short escape.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  // UTF-8 lead byte masks and patterns.
  localparam logic [7:0] UTF_MASK_2 = 8'hE0;
  localparam logic [7:0] UTF_LEAD_2 = 8'hC0;
  localparam logic [7:0] UTF_MASK_3 = 8'hF0;
  localparam logic [7:0] UTF_LEAD_3 = 8'hE0;
  localparam logic [7:0] UTF_MASK_4 = 8'hF8;
  localparam logic [7:0] UTF_LEAD_4 = 8'hF0;

  // Longest body of one item: backslash, u, two zeros and two hex digits.
  localparam int BODY_MAX   = 6;
  localparam int QUEUE_DEPTH = 2;

  // What closes the output of one item.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_QUOTE,
    TAIL_ERROR
  } tail_t;

  // Work descriptor passed from the front end to the back end.
  typedef struct packed {
    logic                         open_q;
    logic [2:0]                   body_len;
    logic [BODY_MAX-1:0][7:0]     body;
    tail_t                        tail;
  } desc_t;

  // Upper-case hex digit of the low nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_UPPER_A + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/jse_front.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input words, tracks UTF-8 sequences and builds one work descriptor
// per input word that yields any output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,
  input  wire logic           in_tlast,
  input  wire logic [1:0]     in_tuser,
  input  wire logic           q_full,
  output logic                q_push,
  output jse_pkg::desc_t      q_wdesc
);
  import jse_pkg::*;

  logic       escape_slash_r;
  logic [1:0] bytes_needed_r, bytes_needed_nxt;
  logic [1:0] held_count_r, held_count_nxt;
  logic [7:0] held_r [0:2];
  logic       held_we;
  logic [1:0] held_idx;

  logic       accept;
  logic       is_first, is_empty;
  logic [7:0] c;
  logic [1:0] need, hcnt, need_dec;
  desc_t      d;
  logic [7:0] esc;

  assign is_first  = in_tuser[0];
  assign is_empty  = in_tuser[1];
  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // A first mark drops any open sequence before the byte is looked at.
  assign need     = is_first ? 2'd0 : bytes_needed_r;
  assign hcnt     = is_first ? 2'd0 : held_count_r;
  assign need_dec = need - 2'd1;

  // Short escape letter of a control byte, or u for the hex form.
  always_comb begin
    case (c)
      CTL_BS:  esc = CH_B;
      CTL_HT:  esc = CH_T;
      CTL_LF:  esc = CH_N;
      CTL_FF:  esc = CH_F;
      CTL_CR:  esc = CH_R;
      default: esc = CH_U;
    endcase
  end

  // Classify the word and build its descriptor and the next sequence state.
  always_comb begin
    d                = '0;
    d.tail           = TAIL_NONE;
    bytes_needed_nxt = need;
    held_count_nxt   = hcnt;
    held_we          = 1'b0;
    held_idx         = hcnt;
    if (is_empty) begin
      d.open_q         = 1'b1;
      d.tail           = TAIL_QUOTE;
      bytes_needed_nxt = 2'd0;
      held_count_nxt   = 2'd0;
    end else begin
      d.open_q = is_first;
      if (need != 2'd0) begin
        // Following byte of a multibyte sequence.
        bytes_needed_nxt = need_dec;
        if (need_dec == 2'd0) begin
          // Held bytes first, then the byte that completes the sequence.
          for (int i = 0; i < 3; i++) begin
            d.body[i] = held_r[i];
          end
          d.body[{1'b0, hcnt}] = c;
          d.body_len     = {1'b0, hcnt} + 3'd1;
          held_count_nxt = 2'd0;
        end else if (hcnt < 2'd3) begin
          held_we        = 1'b1;
          held_count_nxt = hcnt + 2'd1;
        end
      end else if (!c[7]) begin
        // Plain ASCII with escapes.
        if (c < 8'h20) begin
          d.body[0] = CH_BACKSLASH;
          d.body[1] = esc;
          if (esc == CH_U) begin
            d.body[2]  = CH_ZERO;
            d.body[3]  = CH_ZERO;
            d.body[4]  = hex_digit(c[7:4]);
            d.body[5]  = hex_digit(c[3:0]);
            d.body_len = 3'd6;
          end else begin
            d.body_len = 3'd2;
          end
        end else if (c == CH_QUOTE || c == CH_BACKSLASH ||
                     (c == CH_SLASH && escape_slash_r)) begin
          d.body[0]  = CH_BACKSLASH;
          d.body[1]  = c;
          d.body_len = 3'd2;
        end else begin
          d.body[0]  = c;
          d.body_len = 3'd1;
        end
      end else begin
        // Lead byte opens a sequence; anything else is dropped.
        held_idx = 2'd0;
        if ((c & UTF_MASK_2) == UTF_LEAD_2) begin
          bytes_needed_nxt = 2'd1;
          held_we          = 1'b1;
          held_count_nxt   = 2'd1;
        end else if ((c & UTF_MASK_3) == UTF_LEAD_3) begin
          bytes_needed_nxt = 2'd2;
          held_we          = 1'b1;
          held_count_nxt   = 2'd1;
        end else if ((c & UTF_MASK_4) == UTF_LEAD_4) begin
          bytes_needed_nxt = 2'd3;
          held_we          = 1'b1;
          held_count_nxt   = 2'd1;
        end
      end
      // Closing mark: quote, or an error if a sequence is still open.
      if (in_tlast) begin
        if (bytes_needed_nxt != 2'd0) begin
          d.tail           = TAIL_ERROR;
          bytes_needed_nxt = 2'd0;
          held_count_nxt   = 2'd0;
        end else begin
          d.tail = TAIL_QUOTE;
        end
      end
    end
  end

  assign q_wdesc = d;
  assign q_push  = accept && (d.open_q || d.body_len != 3'd0 || d.tail != TAIL_NONE);

  // Configuration and sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_slash_r <= 1'b0;
      bytes_needed_r <= 2'd0;
      held_count_r   <= 2'd0;
    end else begin
      if (cfg_we) begin
        escape_slash_r <= cfg_wdata;
      end
      if (accept) begin
        bytes_needed_r <= bytes_needed_nxt;
        held_count_r   <= held_count_nxt;
      end
    end
  end

  // Held bytes of an open sequence.
  always_ff @(posedge clk) begin
    if (accept && held_we && held_idx != 2'd3) begin
      held_r[held_idx] <= c;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jse_queue.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper descriptor queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jse_pkg::desc_t wdesc,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output jse_pkg::desc_t      rdesc
);
  import jse_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  desc_t               mem_r [0:QUEUE_DEPTH-1];
  logic [PW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [PW:0]         count_r;

  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdesc     = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdesc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/jse_back.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Holds one descriptor and emits its output words one per cycle while
// out_tready is high: optional opening quote, body, closing quote or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire jse_pkg::desc_t q_rdesc,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [1:0]          out_tuser
);
  import jse_pkg::*;

  desc_t      cur_r;
  logic       cur_valid_r;
  logic [2:0] pos_r;

  logic [3:0] total;
  logic [2:0] bidx;
  logic       last_word;
  logic       done_word;
  logic       load;

  assign total     = {3'd0, cur_r.open_q} + {1'b0, cur_r.body_len}
                   + {3'd0, (cur_r.tail != TAIL_NONE)};
  assign bidx      = pos_r - {2'd0, cur_r.open_q};
  assign last_word = ({1'b0, pos_r} == total - 4'd1);
  assign done_word = out_tvalid && out_tready && last_word;
  assign load      = q_not_empty && (!cur_valid_r || done_word);
  assign q_pop     = load;

  // Select the word at the current position.
  always_comb begin
    out_tdata = CH_QUOTE;
    out_tuser = 2'b00;
    if (cur_r.open_q && pos_r == 3'd0) begin
      out_tdata = CH_QUOTE;
    end else if (bidx < cur_r.body_len) begin
      out_tdata = cur_r.body[bidx];
    end else begin
      case (cur_r.tail)
        TAIL_QUOTE: begin
          out_tdata = CH_QUOTE;
          out_tuser = 2'b01;
        end
        TAIL_ERROR: begin
          out_tdata = 8'h00;
          out_tuser = 2'b10;
        end
        default: begin
          out_tdata = CH_QUOTE;
          out_tuser = 2'b00;
        end
      endcase
    end
  end

  assign out_tvalid = cur_valid_r;
  assign out_tlast  = last_word;

  // Current descriptor and word position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else begin
      if (load) begin
        cur_valid_r <= 1'b1;
        pos_r       <= 3'd0;
      end else if (done_word) begin
        cur_valid_r <= 1'b0;
        pos_r       <= 3'd0;
      end else if (out_tvalid && out_tready) begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdesc;
    end
  end

endmodule

`default_nettype wire

// ----- sv/json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns a byte stream into the quoted, escaped JSON form of each string,
// passing UTF-8 sequences through once complete.
//
//   Channel  Direction  Contents
//   in_      slave      tdata: data_byte; tlast: is_last;
//                       tuser: is_first, is_empty
//   out_     master     tdata: out_byte; tlast: run_last;
//                       tuser: string_done, truncated_error
//   cfg_     write      escape_slash
//
// One input word is taken per cycle while the descriptor queue has room.
// Output words leave one per cycle while out_tready is high; an input word
// expands to 1 to 8 bytes; the two-entry queue decouples the sides.
// Reset is synchronous and active low; it clears sequence state, the queue
// and the escape_slash setting. Output stalls fill the queue, then in_tready
// drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,
  input  wire logic [1:0] in_tuser,   // [0] is_first, [1] is_empty
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,
  output logic [1:0]      out_tuser   // [0] string_done, [1] truncated_error
);
  import jse_pkg::*;

  logic  q_push, q_full, q_pop, q_not_empty;
  desc_t q_wdesc, q_rdesc;

  // Front end: classification and UTF-8 tracking.
  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdesc   (q_wdesc)
  );

  // Descriptor queue.
  jse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdesc     (q_wdesc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdesc     (q_rdesc)
  );

  // Back end: output sequencing.
  jse_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdesc     (q_rdesc),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire
